// ----- rtl/uwe_pkg.sv -----
// Shared types and constants of the unique word extractor.
// No dependencies; imported by unique_word_extractor_unit.
package uwe_pkg;

  localparam int WORD_CHARS_DEF  = 16;
  localparam int STORE_DEPTH_DEF = 128;
  localparam int LINE_LIMIT_DEF  = 256;

  localparam int LINE_LEN_W   = 9;
  localparam int LINE_LEN_MAX = 511;

  // in_tdata: char_byte, read_index; out_tdata: see top level
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 152;
  localparam int OUT_USER_W = 2;

  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_WORD_LONG  = 3'd1,
    ERR_LINE_LONG  = 3'd2,
    ERR_STORE_FULL = 3'd3,
    ERR_NO_WORDS   = 3'd4
  } err_t;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SEARCH = 3'b010,
    S_FIN    = 3'b100
  } state_t;

  function automatic logic is_delim(input logic [7:0] c);
    return (c == 8'h2C) || (c == 8'h3B) || (c == 8'h3A) || (c == 8'h20) ||
           (c == 8'h2D) || (c == 8'h2E) || (c == 8'h21) || (c == 8'h3F);
  endfunction

endpackage

// ----- rtl/unique_word_extractor_unit.sv -----
// Unique word extractor: top level with the word store and search sequencer.
// Depends on uwe_pkg.
//
// Bytes of a line come in one word per handshake; the delimiters , ; : space - . ! ?
// split the line into words, and each finished word is looked up in the word store,
// a single-port-read memory of STORE_DEPTH entries. A new word is appended, a repeat
// is reported with the index of its first occurrence. Each input word gives exactly
// one output word. A byte that ends no word, and a read, go straight to commit; a byte
// that ends a word into a non-empty store first runs a search, which reads one stored
// entry per cycle through the store's one read port and stops at the first match or
// at the last stored entry. No new input word is accepted until the last is committed.
// The first byte of a new line empties the store by zeroing its fill count, so there
// is no clearing pass after reset. Errors are sticky until the next line starts; the
// earliest one is reported in status.
module unique_word_extractor_unit #(
  parameter int WORD_CHARS  = uwe_pkg::WORD_CHARS_DEF,
  parameter int STORE_DEPTH = uwe_pkg::STORE_DEPTH_DEF,
  parameter int LINE_LIMIT  = uwe_pkg::LINE_LIMIT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [uwe_pkg::IN_DATA_W-1:0]  in_tdata,   // char_byte[7:0], read_index[14:8]
  input  logic                           in_tuser,   // operation
  input  logic                           in_tlast,   // last_char
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // word_index[6:0], unique_count[14:7], status[17:15], word_low[81:18],
  // word_high[145:82], word_length[150:146]
  output logic [uwe_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic [uwe_pkg::OUT_USER_W-1:0] out_tuser,  // word_complete[0], duplicate[1]
  output logic                           out_tlast   // line_done
);
  import uwe_pkg::*;

  localparam int WW    = WORD_CHARS * 8;
  localparam int LEN_W = $clog2(WORD_CHARS + 1);
  localparam int IDX_W = $clog2(STORE_DEPTH);
  localparam int CNT_W = $clog2(STORE_DEPTH + 1);

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [WW-1:0]    word;
  } entry_t;

  // word store
  entry_t mem [STORE_DEPTH];
  entry_t rd_data_r;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]      count_r;
  logic [WW-1:0]         cur_word_r;
  logic [LEN_W-1:0]      cur_len_r;
  logic [LINE_LEN_W-1:0] llen_r;
  err_t                  err_r;
  logic                  line_ended_r;

  // item being worked on
  logic             kind_r;
  logic             end_r;
  logic             last_r;
  entry_t           pend_r;
  logic [6:0]       ridx_r;
  logic             ridx_hit_r;
  logic             found_r;
  logic [IDX_W-1:0] fidx_r;

  // search pipeline
  logic [CNT_W-1:0] issue_r;
  logic             rd_vld_r;
  logic [IDX_W-1:0] rd_idx_r;

  logic                  out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;
  logic [OUT_USER_W-1:0] out_tuser_r;
  logic                  out_tlast_r;

  logic in_acc, out_free, fin_go;

  // accept-side decode
  logic [7:0]            in_c;
  logic [6:0]            in_ridx;
  logic [CNT_W-1:0]      cnt_eff;
  logic [WW-1:0]         word_eff, word_a;
  logic [LEN_W-1:0]      len_eff, len_a;
  logic [LINE_LEN_W-1:0] llen_eff, llen_a;
  err_t                  err_eff, err_a;
  logic                  delim, end_a, ridx_hit;

  // search compare
  logic issue_en, match, last_cmp;

  // commit
  logic             new_entry, room;
  logic [CNT_W-1:0] count_f;
  err_t             err_f;
  logic             line_f;
  logic [6:0]       widx_f;
  entry_t           wout_f;
  logic [127:0]     wout_wide;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;
  assign fin_go    = (state_r == S_FIN) && out_free;

  assign in_c    = in_tdata[7:0];
  assign in_ridx = in_tdata[14:8];

  always_comb begin
    cnt_eff  = line_ended_r ? '0 : count_r;
    len_eff  = line_ended_r ? '0 : cur_len_r;
    word_eff = line_ended_r ? '0 : cur_word_r;
    llen_eff = line_ended_r ? '0 : llen_r;
    err_eff  = line_ended_r ? ERR_NONE : err_r;
    delim    = is_delim(in_c);

    err_a = err_eff;
    if (err_a == ERR_NONE && llen_eff >= LINE_LEN_W'(LINE_LIMIT)) err_a = ERR_LINE_LONG;
    llen_a = (llen_eff < LINE_LEN_W'(LINE_LEN_MAX)) ? llen_eff + 1'b1 : llen_eff;

    word_a = word_eff;
    len_a  = len_eff;
    if (!delim) begin
      if (len_eff < LEN_W'(WORD_CHARS)) begin
        for (int b = 0; b < WORD_CHARS; b++) begin
          if (len_eff == LEN_W'(b)) word_a[b*8 +: 8] = in_c;
        end
        len_a = len_eff + 1'b1;
      end else if (err_a == ERR_NONE) begin
        err_a = ERR_WORD_LONG;
      end
    end
    // a delimiter ends the word it follows; the final byte ends a word in progress
    end_a = delim ? (len_eff != '0) : (in_tlast && len_a != '0);

    ridx_hit = {1'b0, in_ridx} < 8'(count_r);
  end

  assign issue_en = (state_r == S_SEARCH) && (issue_r < count_r);
  assign match    = rd_vld_r && (rd_data_r == pend_r);
  assign last_cmp = rd_vld_r && (CNT_W'(rd_idx_r) + CNT_W'(1) == count_r);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = issue_r[IDX_W-1:0];
    if (in_acc && in_tuser == OP_READ && ridx_hit) begin
      rd_en   = 1'b1;
      rd_addr = in_ridx[IDX_W-1:0];
    end else if (issue_en) begin
      rd_en = 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_tuser == OP_CHAR && end_a && cnt_eff != '0) state_nxt = S_SEARCH;
          else state_nxt = S_FIN;
        end
      end
      S_SEARCH: if (match || last_cmp) state_nxt = S_FIN;
      S_FIN:    if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // commit of one item
  always_comb begin
    new_entry = end_r && !found_r;
    room      = count_r < CNT_W'(STORE_DEPTH);
    wr_en     = fin_go && new_entry && room;
    count_f   = (new_entry && room) ? count_r + 1'b1 : count_r;
    err_f     = err_r;
    if (new_entry && !room && err_f == ERR_NONE) err_f = ERR_STORE_FULL;
    if (kind_r == OP_CHAR && last_r && count_f == '0 && err_f == ERR_NONE)
      err_f = ERR_NO_WORDS;
    line_f = (kind_r == OP_CHAR && last_r) ? 1'b1 : line_ended_r;

    widx_f = '0;
    wout_f = '0;
    if (kind_r == OP_READ) begin
      widx_f = ridx_r;
      if (ridx_hit_r) wout_f = rd_data_r;
    end else if (end_r) begin
      wout_f = pend_r;
      if (found_r) widx_f = 7'(fidx_r);
      else if (room) widx_f = 7'(count_r);
    end
    wout_wide = 128'(wout_f.word);
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[count_r[IDX_W-1:0]] <= pend_r;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      cur_len_r    <= '0;
      cur_word_r   <= '0;
      llen_r       <= '0;
      err_r        <= ERR_NONE;
      line_ended_r <= 1'b1;
      rd_vld_r     <= 1'b0;
      issue_r      <= '0;
      found_r      <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      // no search read is issued while idle, so this also clears on accept
      rd_vld_r <= issue_en;
      if (issue_en) issue_r <= issue_r + 1'b1;

      if (in_acc && in_tuser == OP_CHAR) begin
        count_r      <= cnt_eff;
        cur_word_r   <= end_a ? '0 : word_a;
        cur_len_r    <= end_a ? '0 : len_a;
        llen_r       <= llen_a;
        err_r        <= err_a;
        line_ended_r <= 1'b0;
      end
      if (in_acc) begin
        found_r <= 1'b0;
        issue_r <= '0;
      end

      if (state_r == S_SEARCH && match) found_r <= 1'b1;

      if (fin_go) begin
        count_r      <= count_f;
        err_r        <= err_f;
        line_ended_r <= line_f;
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rd_idx_r <= issue_r[IDX_W-1:0];
    if (in_acc) begin
      kind_r     <= in_tuser;
      end_r      <= (in_tuser == OP_CHAR) && end_a;
      last_r     <= in_tlast;
      pend_r     <= '{len: len_a, word: word_a};
      ridx_r     <= in_ridx;
      ridx_hit_r <= ridx_hit;
    end
    if (state_r == S_SEARCH && match) fidx_r <= rd_idx_r;
    if (fin_go) begin
      out_tdata_r <= {1'b0, 5'(wout_f.len), wout_wide[127:64], wout_wide[63:0],
                      3'(err_f), 8'(count_f), widx_f};
      out_tuser_r <= {(end_r && found_r), end_r};
      out_tlast_r <= line_f;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;

  // fill count stays within the store
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(STORE_DEPTH))
    else $error("unique count beyond store depth");

  // a search only runs over a non-empty store
  a_search_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SEARCH |-> count_r != '0)
    else $error("search with empty store");

  // a new output word only follows a commit
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r == S_FIN))
    else $error("output raised outside commit");

  // a duplicate is always a completed word
  a_dup_complete: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && out_tuser_r[1] |-> out_tuser_r[0])
    else $error("duplicate without completed word");

  // no new item is taken while the store is written
  a_wr_idle: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !in_tready)
    else $error("store write while accepting");

endmodule

// ----- dv/tb_unique_word_extractor_unit.sv -----
// Self-checking testbench for unique_word_extractor_unit: directed and random lines
// through the byte stream, each output word checked against a built-in predictor.
// Depends on uwe_pkg and the unique_word_extractor_unit RTL.
`timescale 1ns / 100ps

module tb_unique_word_extractor_unit;
  import uwe_pkg::*;

  localparam int WORD_MAX    = WORD_CHARS_DEF;
  localparam int DEPTH       = STORE_DEPTH_DEF;
  localparam int LIMIT       = LINE_LIMIT_DEF;
  localparam int N_ITEMS     = 1550;
  localparam int TAIL        = 150;
  localparam int MAX_CYCLES  = 2_000_000;
  localparam int SETTLE      = 2 * (DEPTH + 3) + 20;

  localparam logic [7:0] SEPS [8] = '{8'h2C, 8'h3B, 8'h3A, 8'h20, 8'h2D, 8'h2E, 8'h21, 8'h3F};

  typedef struct packed {
    logic       op;
    logic [7:0] chr;
    logic       last;
    logic [6:0] ridx;
    logic       drain;   // hold this word back until all results are in
  } in_word_t;

  typedef struct packed {
    logic        word_end;
    logic        dup;
    logic [6:0]  idx;
    logic [7:0]  count;
    err_t        status;
    logic        line_done;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [4:0]  len;
  } status_word_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  in_tlast = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;
  logic                  out_tlast;

  unique_word_extractor_unit uut (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser, .in_tlast,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast
  );

  always #6 clk = ~clk;

  in_word_t     pending_words[$];
  status_word_t expected_status[$];

  // predictor state
  logic [63:0] st_lo [DEPTH];
  logic [63:0] st_hi [DEPTH];
  logic [4:0]  st_len [DEPTH];
  int          n_stored = 0;
  logic [63:0] cur_lo = '0;
  logic [63:0] cur_hi = '0;
  int          cur_len = 0;
  int          line_len = 0;
  err_t        line_err = ERR_NONE;
  logic        line_over = 1'b1;

  int          n_errors = 0;
  int          n_cycles = 0;
  int          n_chars = 0;
  int          n_reads = 0;
  int          n_word_ends = 0;
  int          n_repeats = 0;
  logic [4:0]  status_seen = '0;

  // generator vocabulary
  logic [7:0]  voc_chr [8][20];
  int          voc_len [8];

  function automatic logic is_separator(input logic [7:0] c);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < 8; i++)
      if (SEPS[i] == c) hit = 1'b1;
    return hit;
  endfunction

  function automatic void flag_err(input err_t e);
    if (line_err == ERR_NONE) line_err = e;
  endfunction

  // look the collected word up in the store, append it if new
  function automatic status_word_t close_word();
    status_word_t w;
    int hit;
    w = '0;
    hit = -1;
    for (int i = 0; i < n_stored; i++)
      if (hit < 0 && st_len[i] == cur_len && st_lo[i] == cur_lo && st_hi[i] == cur_hi)
        hit = i;
    w.word_end = 1'b1;
    if (hit >= 0) begin
      w.dup = 1'b1;
      w.idx = 7'(hit);
    end else if (n_stored < DEPTH) begin
      st_lo[n_stored]  = cur_lo;
      st_hi[n_stored]  = cur_hi;
      st_len[n_stored] = 5'(cur_len);
      w.idx = 7'(n_stored);
      n_stored++;
    end else begin
      flag_err(ERR_STORE_FULL);
    end
    w.lo  = cur_lo;
    w.hi  = cur_hi;
    w.len = 5'(cur_len);
    cur_lo  = '0;
    cur_hi  = '0;
    cur_len = 0;
    return w;
  endfunction

  function automatic status_word_t extract_step(input in_word_t it);
    status_word_t r;
    r = '0;
    if (it.op == OP_READ) begin
      r.idx = it.ridx;
      if (it.ridx < n_stored) begin
        r.lo  = st_lo[it.ridx];
        r.hi  = st_hi[it.ridx];
        r.len = st_len[it.ridx];
      end
    end else begin
      if (line_over) begin
        n_stored  = 0;
        cur_lo    = '0;
        cur_hi    = '0;
        cur_len   = 0;
        line_len  = 0;
        line_err  = ERR_NONE;
        line_over = 1'b0;
      end
      if (line_len >= LIMIT) flag_err(ERR_LINE_LONG);
      if (line_len < LINE_LEN_MAX) line_len++;
      if (is_separator(it.chr)) begin
        if (cur_len > 0) r = close_word();
      end else if (cur_len < WORD_MAX) begin
        if (cur_len < 8) cur_lo[8*cur_len +: 8] = it.chr;
        else             cur_hi[8*(cur_len-8) +: 8] = it.chr;
        cur_len++;
      end else begin
        flag_err(ERR_WORD_LONG);
      end
      if (it.last) begin
        if (cur_len > 0) r = close_word();
        if (n_stored == 0) flag_err(ERR_NO_WORDS);
        line_over = 1'b1;
      end
    end
    r.count     = 8'(n_stored);
    r.status    = line_err;
    r.line_done = line_over;
    return r;
  endfunction

  // ---------------- stimulus generation ----------------

  task automatic push_word_in(input logic op, input logic [7:0] c, input logic l,
                              input logic [6:0] r);
    in_word_t w;
    w.op = op;
    w.chr = c;
    w.last = l;
    w.ridx = r;
    w.drain = 1'b0;
    pending_words.push_back(w);
  endtask

  task automatic push_char(input logic [7:0] c, input logic l);
    push_word_in(OP_CHAR, c, l, 7'($urandom));
  endtask

  task automatic push_read(input logic [6:0] r);
    push_word_in(OP_READ, 8'($urandom), 1'($urandom), r);
  endtask

  function automatic logic [7:0] pick_sep();
    return SEPS[$urandom_range(0, 7)];
  endfunction

  function automatic logic [7:0] pick_letter();
    logic [7:0] c;
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    do c = 8'($urandom); while (is_separator(c));
    return c;
  endfunction

  task automatic new_vocab();
    for (int v = 0; v < 8; v++) begin
      voc_len[v] = ($urandom_range(0, 19) == 0) ? $urandom_range(17, 20) : $urandom_range(1, 16);
      for (int k = 0; k < 20; k++) voc_chr[v][k] = pick_letter();
    end
    // near miss: same bytes plus one more, often a zero byte
    if (voc_len[0] < WORD_MAX && $urandom_range(0, 2) == 0) begin
      voc_chr[1] = voc_chr[0];
      voc_len[1] = voc_len[0] + 1;
      if ($urandom_range(0, 1) == 0) voc_chr[1][voc_len[0]] = 8'h00;
    end
  endtask

  task automatic push_vocab_word(input int v, input logic last_on_end);
    for (int i = 0; i < voc_len[v]; i++)
      push_char(voc_chr[v][i], last_on_end && i == voc_len[v] - 1);
  endtask

  task automatic gen_plain_line();
    int nw;
    int s;
    logic end_on_letter;
    nw = $urandom_range(1, 12);
    end_on_letter = 1'($urandom);
    if ($urandom_range(0, 1) == 0) new_vocab();
    if ($urandom_range(0, 4) == 0) push_char(pick_sep(), 1'b0);
    for (int w = 0; w < nw; w++) begin
      if ($urandom_range(0, 9) == 0) push_read(7'($urandom));
      push_vocab_word($urandom_range(0, 7), end_on_letter && w == nw - 1);
      if (!(end_on_letter && w == nw - 1)) begin
        s = $urandom_range(1, 3);
        for (int k = 0; k < s; k++)
          push_char(pick_sep(), !end_on_letter && w == nw - 1 && k == s - 1);
      end
    end
  endtask

  task automatic gen_noise_line();
    int n;
    n = $urandom_range(1, 40);
    for (int i = 0; i < n; i++)
      push_char(($urandom_range(0, 9) < 3) ? pick_sep() : 8'($urandom), i == n - 1);
  endtask

  task automatic gen_blank_line();
    int n;
    n = $urandom_range(1, 4);
    for (int i = 0; i < n; i++) push_char(pick_sep(), i == n - 1);
  endtask

  // 128 distinct one-byte words, then one more new word, then three reads
  task automatic gen_full_store(input logic spill);
    logic [7:0] letters[$];
    logic [7:0] t;
    int j;
    for (int b = 0; b < 256; b++)
      if (!is_separator(8'(b))) letters.push_back(8'(b));
    for (int i = letters.size() - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = letters[i];
      letters[i] = letters[j];
      letters[j] = t;
    end
    for (int i = 0; i < DEPTH; i++) begin
      push_char(letters[i], 1'b0);
      push_char(pick_sep(), 1'b0);
    end
    if (!spill) begin
      push_char(letters[DEPTH], 1'b1);
    end else begin
      push_char(letters[DEPTH], 1'b0);
      push_char(pick_sep(), 1'b1);
    end
    push_read(7'd127);
    push_read(7'd0);
    push_read(7'd64);
  endtask

  // line overflow and word overflow on the same byte
  task automatic gen_edge_line();
    for (int i = 0; i < 120; i++) begin
      push_char(8'h78, 1'b0);
      push_char(8'h20, 1'b0);
    end
    for (int i = 0; i < 17; i++) push_char(8'h79, 1'b0);
    push_char(8'h2E, 1'b1);
  endtask

  // runs well past the 9-bit length counter's top
  task automatic gen_marathon_line();
    int start;
    start = pending_words.size();
    new_vocab();
    while (pending_words.size() - start < 530) begin
      push_vocab_word($urandom_range(0, 7), 1'b0);
      push_char(pick_sep(), 1'b0);
    end
    push_char(pick_sep(), 1'b1);
  endtask

  task automatic build_stimulus();
    int first;
    int kind;
    logic spilled;
    spilled = 1'b0;
    // directed: repeats, zero byte, length-only difference, reads, all delimiters
    push_char(8'h61, 1'b0);
    push_char(8'h62, 1'b0);
    push_char(8'h20, 1'b0);
    push_char(8'h61, 1'b0);
    push_char(8'h62, 1'b0);
    push_char(8'h2C, 1'b0);
    push_char(8'h61, 1'b0);
    push_char(8'h00, 1'b0);
    push_char(8'h3B, 1'b0);
    push_read(7'd0);
    push_read(7'd1);
    push_char(8'h61, 1'b1);
    push_read(7'd2);
    push_char(8'h2D, 1'b0);
    push_char(8'h21, 1'b0);
    push_char(8'h3F, 1'b0);
    push_char(8'h3A, 1'b0);
    push_char(8'h2E, 1'b1);
    push_read(7'd0);
    push_char(8'hFF, 1'b1);
    push_read(7'd0);

    gen_full_store(1'b0);
    first = pending_words.size();
    gen_edge_line();
    pending_words[first].drain = 1'b1;
    gen_marathon_line();
    new_vocab();
    while (pending_words.size() < N_ITEMS) begin
      first = pending_words.size();
      kind = $urandom_range(0, 99);
      if (!spilled && first > N_ITEMS / 2) begin
        gen_full_store(1'b1);
        spilled = 1'b1;
      end else if (kind < 8) begin
        gen_noise_line();
      end else if (kind < 13) begin
        gen_blank_line();
      end else begin
        gen_plain_line();
      end
      if ($urandom_range(0, 24) == 0) pending_words[first].drain = 1'b1;
    end
  endtask

  // ---------------- driver ----------------

  in_word_t cur_in;
  in_word_t nxt_in;
  int       send_gap = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_status.push_back(extract_step(cur_in));
        if (cur_in.op == OP_READ) n_reads++;
        else                      n_chars++;
      end
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_words.size() > 0 &&
                     !(pending_words[0].drain && expected_status.size() > 0)) begin
          nxt_in = pending_words.pop_front();
          cur_in = nxt_in;
          in_tdata  <= {1'b0, nxt_in.ridx, nxt_in.chr};
          in_tuser  <= nxt_in.op;
          in_tlast  <= nxt_in.last;
          in_tvalid <= 1'b1;
          if (pending_words.size() > TAIL && $urandom_range(0, 9) == 0)
            send_gap = $urandom_range(1, 18);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------- monitor ----------------

  task automatic check_field(input string what, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      n_errors++;
    end
  endtask

  status_word_t exp_w;
  int           recv_stall = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_status.size() == 0) begin
          $display("%0t: unexpected output word, expected none, got index %0h status %0h",
                   $time, out_tdata[6:0], out_tdata[17:15]);
          n_errors++;
        end else begin
          exp_w = expected_status.pop_front();
          check_field("word_complete", exp_w.word_end,  out_tuser[0]);
          check_field("duplicate",     exp_w.dup,       out_tuser[1]);
          check_field("word_index",    exp_w.idx,       out_tdata[6:0]);
          check_field("unique_count",  exp_w.count,     out_tdata[14:7]);
          check_field("status",        exp_w.status,    out_tdata[17:15]);
          check_field("line_done",     exp_w.line_done, out_tlast);
          check_field("word_low",      exp_w.lo,        out_tdata[81:18]);
          check_field("word_high",     exp_w.hi,        out_tdata[145:82]);
          check_field("word_length",   exp_w.len,       out_tdata[150:146]);
          if (exp_w.word_end) n_word_ends++;
          if (exp_w.dup) n_repeats++;
          status_seen[exp_w.status] = 1'b1;
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (pending_words.size() > TAIL && $urandom_range(0, 11) == 0)
          recv_stall = $urandom_range(1, 18);
      end
    end
  end

  // ---------------- watchdog ----------------

  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles == MAX_CYCLES) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               n_cycles, expected_status.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------- sequence ----------------

  initial begin
    build_stimulus();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_words.size() != 0 || in_tvalid || expected_status.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    $display("Sent %0d bytes and %0d reads; checked %0d word ends, %0d of them repeats",
             n_chars, n_reads, n_word_ends, n_repeats);
    $display("Status codes observed (bit per code): %b, mismatches: %0d",
             status_seen, n_errors);
    if (n_errors == 0) $display("Simulation PASSED");
    else               $display("Simulation FAILED");
    $finish;
  end

endmodule
